// ===== hdl/hblw_pkg.sv =====
// Shared types and constants for the height-band layer weight block.
// No dependencies; used by height_band_layer_weights.
`default_nettype none
package hblw_pkg;

  localparam int NUM_BANDS  = 4;
  localparam int MAX_LAYERS = 4;
  localparam int BAND_BITS  = 18;
  localparam int BOUND_BITS = 9;
  localparam int CFG_IDX_BITS = 3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BAND_ZERO   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BAND_ONE    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BAND_TWO    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BAND_THREE  = 3'd4;

  typedef struct packed {
    logic [7:0] height;
    logic       last_pixel;
  } pix_t;

  typedef struct packed {
    logic [7:0] weight_zero;
    logic [7:0] weight_one;
    logic [7:0] weight_two;
    logic [7:0] weight_three;
    logic       last_out;
  } wt_t;

endpackage
`default_nettype wire

// ===== hdl/height_band_layer_weights.sv =====
// Height-band layer weights: 27-stage pipeline from height sample to blend weights.
// Depends on hblw_pkg.
//
// One pixel request is taken every cycle while the result side keeps up; each
// request passes through every stage in order. The depth is set by two bit-serial
// dividers laid out as stages: 16 restoring steps for the Q0.16 tent weights
// (four layers side by side) and 8 steps for the normalisation by the weight
// sum, plus an input stage, a summing stage and a scaling stage. Every stage
// has its own valid bit and is loaded whenever it is empty or its successor
// moves, so bubbles close up and a stall holds every request in place.
`default_nettype none
module height_band_layer_weights #(
  parameter int MAX_LAYERS = hblw_pkg::MAX_LAYERS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              pix_valid,
  output      logic                              pix_ready,
  input  wire hblw_pkg::pix_t                    pix,
  output      logic                              wt_valid,
  input  wire logic                              wt_ready,
  output      hblw_pkg::wt_t                     wt,
  input  wire logic                              cfg_we,
  input  wire logic [hblw_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [hblw_pkg::BAND_BITS-1:0]    cfg_data
);

  localparam int NB    = hblw_pkg::NUM_BANDS;
  localparam int LIM   = (MAX_LAYERS > NB) ? NB : MAX_LAYERS;
  localparam int NSTG  = 27;
  localparam int S_SUM = 17;
  localparam int S_SCL = 18;

  typedef struct packed {
    logic                 last;
    logic                 zero;
    logic [NB-1:0]        full;
    logic [NB-1:0][9:0]   rem;
    logic [NB-1:0][8:0]   den;
    logic [NB-1:0][16:0]  q;
    logic [NB-1:0][26:0]  numer;
    logic [19:0]          d;
  } stg_t;

  logic [2:0]                    layer_count;
  logic [NB-1:0][17:0]           band;
  stg_t                          pipe [NSTG];
  logic [NSTG-1:0]               v;
  logic [NSTG-1:0]               adv;
  stg_t                          stg_next [NSTG];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= '0;
      band        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hblw_pkg::REG_LAYER_COUNT: begin
          layer_count <= (cfg_data[2:0] > 3'(LIM)) ? 3'(LIM) : cfg_data[2:0];
        end
        hblw_pkg::REG_BAND_ZERO:  band[0] <= cfg_data;
        hblw_pkg::REG_BAND_ONE:   band[1] <= cfg_data;
        hblw_pkg::REG_BAND_TWO:   band[2] <= cfg_data;
        hblw_pkg::REG_BAND_THREE: band[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage handshake
  always_comb begin
    adv[NSTG-1] = !v[NSTG-1] || wt_ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      adv[s] = !v[s] || adv[s+1];
    end
  end
  assign pix_ready = adv[0];

  // stage logic
  always_comb begin
    logic [9:0]  lo, hi, hh, mid;
    logic [10:0] sh;
    logic [18:0] sum;
    logic [26:0] cmp;
    logic [16:0] w;
    int          k;
    stg_next[0]      = '0;
    stg_next[0].last = pix.last_pixel;
    hh = {2'b00, pix.height};
    for (int j = 0; j < NB; j++) begin
      lo  = {1'b0, band[j][8:0]};
      hi  = {1'b0, band[j][17:9]};
      mid = 10'((11'(lo) + 11'(hi)) >> 1);
      if ((3'(j) < layer_count) && (hh > lo) && (hh < hi)) begin
        if (hh < mid) begin
          stg_next[0].rem[j] = hh - lo;
          stg_next[0].den[j] = 9'(mid - lo);
        end else begin
          stg_next[0].rem[j] = hi - hh;
          stg_next[0].den[j] = 9'(hi - mid);
        end
      end else begin
        stg_next[0].rem[j] = '0;
        stg_next[0].den[j] = 9'd1;
      end
      // sample at the midpoint: full weight
      stg_next[0].full[j] = (stg_next[0].rem[j] == {1'b0, stg_next[0].den[j]});
    end
    for (int s = 1; s < NSTG; s++) begin
      if (s < S_SUM) begin
        stg_next[s] = pipe[s-1];
        for (int j = 0; j < NB; j++) begin
          sh = {pipe[s-1].rem[j], 1'b0};
          if (sh >= {2'b00, pipe[s-1].den[j]}) begin
            stg_next[s].rem[j] = 10'(sh - {2'b00, pipe[s-1].den[j]});
            stg_next[s].q[j]   = {pipe[s-1].q[j][15:0], 1'b1};
          end else begin
            stg_next[s].rem[j] = sh[9:0];
            stg_next[s].q[j]   = {pipe[s-1].q[j][15:0], 1'b0};
          end
        end
      end else if (s == S_SUM) begin
        stg_next[s] = pipe[s-1];
        sum = '0;
        for (int j = 0; j < NB; j++) begin
          w = pipe[s-1].full[j] ? 17'h10000 : {1'b0, pipe[s-1].q[j][15:0]};
          stg_next[s].q[j] = w;
          sum = sum + 19'(w);
        end
        stg_next[s].d = {1'b0, sum};
      end else if (s == S_SCL) begin
        stg_next[s]      = pipe[s-1];
        stg_next[s].zero = (pipe[s-1].d == '0);
        stg_next[s].d    = {pipe[s-1].d[18:0], 1'b0};
        for (int j = 0; j < NB; j++) begin
          // 510*w + S
          stg_next[s].numer[j] = ({10'b0, pipe[s-1].q[j]} << 9)
                               - ({10'b0, pipe[s-1].q[j]} << 1)
                               + {8'b0, pipe[s-1].d[18:0]};
          stg_next[s].q[j] = '0;
        end
      end else begin
        stg_next[s] = pipe[s-1];
        k   = NSTG - 1 - s;
        cmp = {7'b0, pipe[s-1].d} << k;
        for (int j = 0; j < NB; j++) begin
          if (pipe[s-1].numer[j] >= cmp) begin
            stg_next[s].numer[j] = pipe[s-1].numer[j] - cmp;
            stg_next[s].q[j]     = {pipe[s-1].q[j][15:0], 1'b1};
          end else begin
            stg_next[s].q[j]     = {pipe[s-1].q[j][15:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= pix_valid;
      for (int s = 1; s < NSTG; s++) begin
        if (adv[s]) v[s] <= v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (adv[s]) pipe[s] <= stg_next[s];
    end
  end

  always_comb begin
    wt          = '0;
    wt.last_out = pipe[NSTG-1].last;
    if (!pipe[NSTG-1].zero) begin
      wt.weight_zero  = pipe[NSTG-1].q[0][7:0];
      wt.weight_one   = pipe[NSTG-1].q[1][7:0];
      wt.weight_two   = pipe[NSTG-1].q[2][7:0];
      wt.weight_three = pipe[NSTG-1].q[3][7:0];
    end
  end
  assign wt_valid = v[NSTG-1];

  logic [9:0] wsum;
  assign wsum = 10'(wt.weight_zero) + 10'(wt.weight_one)
              + 10'(wt.weight_two) + 10'(wt.weight_three);

  // rounded shares of a nonzero sum add up to within two of full scale
  a_wsum: assert property (@(posedge clk) disable iff (rst)
    wt_valid && !pipe[NSTG-1].zero |-> (wsum >= 10'd253) && (wsum <= 10'd257))
    else $error("normalised weights do not add up to full scale");

  a_inactive: assert property (@(posedge clk) disable iff (rst)
    wt_valid && (layer_count < 3'd4) |-> wt.weight_three == 8'd0)
    else $error("inactive layer has a weight");

  a_full: assert property (@(posedge clk) disable iff (rst)
    v[S_SUM] |-> pipe[S_SUM].d <= 20'(NB * 65536))
    else $error("tent weight sum out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v[S_SCL] && !adv[S_SCL] |=> v[S_SCL] && $stable(pipe[S_SCL].d))
    else $error("stalled stage lost its request");

endmodule
`default_nettype wire

// ===== verif/height_band_layer_weights_tb.sv =====
// Self-checking testbench for height_band_layer_weights: random pixel requests,
// predicted blend weights compared in order by a small scoreboard class.
// Depends on hblw_pkg and the height_band_layer_weights RTL.
`timescale 1ns / 1ps
module height_band_layer_weights_tb;

  localparam int PIPE_DEPTH = 27;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst;
  logic pix_valid, pix_ready, wt_valid, wt_ready, cfg_we;
  hblw_pkg::pix_t pix;
  hblw_pkg::wt_t wt;
  logic [hblw_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [hblw_pkg::BAND_BITS-1:0] cfg_data;
  int mismatches = 0;
  int cycles = 0;
  bit quiet_run = 0;

  logic [2:0] active_layers;
  logic [hblw_pkg::BAND_BITS-1:0] bands [hblw_pkg::NUM_BANDS];

  height_band_layer_weights uut (
    .clk(clk), .rst(rst), .pix_valid(pix_valid), .pix_ready(pix_ready), .pix(pix),
    .wt_valid(wt_valid), .wt_ready(wt_ready), .wt(wt),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic longint tent(input int h, input logic [hblw_pkg::BAND_BITS-1:0] b);
    int lo, hi, mid, num, den;
    lo = b[8:0];
    hi = b[17:9];
    if (!(h > lo && h < hi)) return 0;
    mid = (lo + hi) >> 1;
    if (h < mid) begin
      num = h - lo;
      den = mid - lo;
    end else begin
      num = hi - h;
      den = hi - mid;
    end
    if (den == 0) return 0;
    return (longint'(num) * 65536) / den;
  endfunction

  function automatic hblw_pkg::wt_t blend_weights(input hblw_pkg::pix_t p);
    longint w [hblw_pkg::NUM_BANDS];
    longint sum, r;
    logic [7:0] b [hblw_pkg::NUM_BANDS];
    hblw_pkg::wt_t o;
    sum = 0;
    for (int j = 0; j < hblw_pkg::NUM_BANDS; j++) begin
      w[j] = (j < active_layers) ? tent(p.height, bands[j]) : 0;
      sum += w[j];
    end
    for (int j = 0; j < hblw_pkg::NUM_BANDS; j++) begin
      r = (sum != 0) ? (510 * w[j] + sum) / (2 * sum) : 0;
      if (r > 255) r = 255;
      b[j] = r[7:0];
    end
    o.weight_zero = b[0];
    o.weight_one = b[1];
    o.weight_two = b[2];
    o.weight_three = b[3];
    o.last_out = p.last_pixel;
    return o;
  endfunction

  class weight_board;
    hblw_pkg::wt_t pending [$];
    function void note_pixel(hblw_pkg::pix_t p);
      pending.push_back(blend_weights(p));
    endfunction
    task check_weights(hblw_pkg::wt_t got);
      hblw_pkg::wt_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.weight_zero != want.weight_zero)
        report("weight_zero", got.weight_zero, want.weight_zero);
      if (got.weight_one != want.weight_one)
        report("weight_one", got.weight_one, want.weight_one);
      if (got.weight_two != want.weight_two)
        report("weight_two", got.weight_two, want.weight_two);
      if (got.weight_three != want.weight_three)
        report("weight_three", got.weight_three, want.weight_three);
      if (got.last_out != want.last_out)
        report("last_out", got.last_out, want.last_out);
    endtask
  endclass

  weight_board board = new();

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("height_band_layer_weights_tb NOT OK");
      $finish;
    end
  end

  // result side: sample at the edge, then choose the next ready
  always @(posedge clk) begin
    if (!rst && wt_valid && wt_ready) board.check_weights(wt);
    if (rst) wt_ready <= 1'b0;
    else wt_ready <= quiet_run || ($urandom_range(99) >= 15);
  end

  task automatic write_reg(input logic [hblw_pkg::CFG_IDX_BITS-1:0] idx, input int val);
    logic [hblw_pkg::BAND_BITS-1:0] v;
    v = hblw_pkg::BAND_BITS'(val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hblw_pkg::REG_LAYER_COUNT) active_layers = (v[2:0] > 4) ? 3'd4 : v[2:0];
    else bands[2'(idx - 1)] = v;
    @(posedge clk);
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  // valid stays high after the accepting edge; the next idle or drain takes it
  // down, or the next request replaces the pixel, in that same step
  task automatic send_pixel(input int h, input bit last);
    hblw_pkg::pix_t p;
    if (!quiet_run)
      while ($urandom_range(99) < 15) begin
        pix_valid <= 1'b0;
        @(posedge clk);
      end
    p.height = 8'(h);
    p.last_pixel = last;
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (!pix_ready);
    board.note_pixel(p);
  endtask

  function automatic int make_band(input int lo, input int hi);
    return (hi << 9) | lo;
  endfunction

  task automatic random_setting();
    int lo, hi;
    write_reg(hblw_pkg::REG_LAYER_COUNT, $urandom_range(7));
    for (int j = 0; j < hblw_pkg::NUM_BANDS; j++) begin
      case ($urandom_range(3))
        0: write_reg(3'(hblw_pkg::REG_BAND_ZERO + j), $urandom_range(262143));
        default: begin
          lo = $urandom_range(255);
          hi = lo + $urandom_range(1, 256);
          if (hi > 511) hi = 511;
          write_reg(3'(hblw_pkg::REG_BAND_ZERO + j), make_band(lo, hi));
        end
      endcase
    end
  endtask

  initial begin
    int lo;
    rst = 1'b1;
    pix_valid = 1'b0;
    pix = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    active_layers = 0;
    for (int j = 0; j < hblw_pkg::NUM_BANDS; j++) bands[j] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state: no layers, all weights zero
    send_pixel(0, 0);
    send_pixel(255, 1);
    drain();

    // overlapping bands, one empty, one inverted, one full range
    write_reg(hblw_pkg::REG_LAYER_COUNT, 7);
    write_reg(hblw_pkg::REG_BAND_ZERO, make_band(0, 100));
    write_reg(hblw_pkg::REG_BAND_ONE, make_band(50, 51));
    write_reg(hblw_pkg::REG_BAND_TWO, make_band(200, 20));
    write_reg(hblw_pkg::REG_BAND_THREE, make_band(0, 511));
    send_pixel(50, 0);   // midpoint of band zero
    send_pixel(1, 0);
    send_pixel(99, 0);
    send_pixel(100, 0);
    send_pixel(255, 1);
    send_pixel(0, 0);    // zero sum
    drain();
    write_reg(hblw_pkg::REG_LAYER_COUNT, 2);
    write_reg(hblw_pkg::REG_BAND_THREE, make_band(10, 12));
    send_pixel(50, 1);
    send_pixel(11, 0);
    send_pixel(170, 0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      random_setting();
      quiet_run = (ph == 5);
      for (int i = 0; i < 100; i++) begin
        lo = bands[$urandom_range(3)][8:0];
        if ($urandom_range(3) == 0)
          send_pixel($urandom_range(255), 1'($urandom_range(1)));
        else send_pixel((lo + $urandom_range(0, 40)) & 8'hFF, 1'($urandom_range(1)));
        if (i == 50) begin
          pix_valid <= 1'b0;
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
      quiet_run = 0;
      drain();
    end

    // extremes of the count and the bounds
    write_reg(hblw_pkg::REG_LAYER_COUNT, 4);
    write_reg(hblw_pkg::REG_BAND_ZERO, 262143);
    write_reg(hblw_pkg::REG_BAND_ONE, make_band(255, 511));
    write_reg(hblw_pkg::REG_BAND_TWO, make_band(0, 256));
    write_reg(hblw_pkg::REG_BAND_THREE, make_band(254, 256));
    for (int i = 0; i < 50; i++) send_pixel($urandom_range(255), 1'($urandom_range(1)));
    drain();

    if (mismatches == 0) $display("height_band_layer_weights_tb OK");
    else $display("height_band_layer_weights_tb NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/hblw_pkg.sv
hdl/height_band_layer_weights.sv
verif/height_band_layer_weights_tb.sv
